// ===== rtl/log_class_border_generator_core_defines.svh =====
// assertion macros for the class border generator
`ifndef LOG_CLASS_BORDER_GENERATOR_CORE_DEFINES_SVH
`define LOG_CLASS_BORDER_GENERATOR_CORE_DEFINES_SVH

// condition holds in the same cycle
`define LCBG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcbg assertion failed");

// condition holds in the next cycle
`define LCBG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcbg assertion failed");

`endif

// ===== rtl/lcbg_pkg.sv =====
// shared types, constants and tables of the class border generator
package lcbg_pkg;

	localparam int LOG_FRAC  = 24;
	localparam int MANT_FRAC = 30;
	localparam int LOGW      = 40;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_NORM,
		OP_LOG_INIT,
		OP_SQ_MUL,
		OP_SQ_ADJ,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_EXP_INIT,
		OP_EXP_MUL,
		OP_EXP_ADJ,
		OP_EXP_SHIFT,
		OP_EMIT_ERR,
		OP_EMIT_LOW,
		OP_EMIT_MID,
		OP_EMIT_HIGH
	} op_t;

	typedef struct packed {
		logic err;
		logic norm_done;
		logic cnt_last;
		logic div_last;
		logic mid_done;
		logic out_free;
	} status_t;

	typedef logic [LOG_FRAC-1:0][MANT_FRAC:0] root_arr_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		x = v;
		b = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-(k+1)) in q1.30, each the truncated root of the one before
	function automatic root_arr_t root_table();
		root_arr_t t;
		logic [63:0] r;
		r = isqrt64(64'd2 << (2 * MANT_FRAC));
		for (int k = 0; k < LOG_FRAC; k++) begin
			t[k] = r[MANT_FRAC:0];
			r = isqrt64(r << MANT_FRAC);
		end
		return t;
	endfunction

endpackage

// ===== rtl/lcbg_ctrl.sv =====
// sequencer of the class border generator
module lcbg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lcbg_pkg::status_t stat,
	output lcbg_pkg::op_t    op
);
	import lcbg_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_EMIT_ERR, S_EMIT_LOW, S_NORM, S_SQ_MUL, S_SQ_ADJ,
		S_DIV_INIT, S_DIV_STEP, S_DIV_DONE, S_EXP_CHECK, S_EXP_INIT, S_EXP_MUL,
		S_EXP_ADJ, S_EXP_SHIFT, S_EMIT_MID, S_EMIT_HIGH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = stat.err ? S_EMIT_ERR : S_EMIT_LOW;
			S_EMIT_ERR: if (stat.out_free) begin
				op      = OP_EMIT_ERR;
				state_d = S_IDLE;
			end
			S_EMIT_LOW: if (stat.out_free) begin
				op      = OP_EMIT_LOW;
				state_d = S_NORM;
			end
			S_NORM: begin
				if (stat.norm_done) begin
					op      = OP_LOG_INIT;
					state_d = S_SQ_MUL;
				end else begin
					op = OP_NORM;
				end
			end
			S_SQ_MUL: begin
				op      = OP_SQ_MUL;
				state_d = S_SQ_ADJ;
			end
			S_SQ_ADJ: begin
				op      = OP_SQ_ADJ;
				state_d = stat.cnt_last ? S_DIV_INIT : S_SQ_MUL;
			end
			S_DIV_INIT: begin
				op      = OP_DIV_INIT;
				state_d = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				op = OP_DIV_STEP;
				if (stat.div_last) state_d = S_DIV_DONE;
			end
			S_DIV_DONE: begin
				op      = OP_DIV_DONE;
				state_d = S_EXP_CHECK;
			end
			S_EXP_CHECK: state_d = stat.mid_done ? S_EMIT_HIGH : S_EXP_INIT;
			S_EXP_INIT: begin
				op      = OP_EXP_INIT;
				state_d = S_EXP_MUL;
			end
			S_EXP_MUL: begin
				op      = OP_EXP_MUL;
				state_d = S_EXP_ADJ;
			end
			S_EXP_ADJ: begin
				op      = OP_EXP_ADJ;
				state_d = stat.cnt_last ? S_EXP_SHIFT : S_EXP_MUL;
			end
			S_EXP_SHIFT: begin
				op      = OP_EXP_SHIFT;
				state_d = S_EMIT_MID;
			end
			S_EMIT_MID: if (stat.out_free) begin
				op      = OP_EMIT_MID;
				state_d = S_EXP_CHECK;
			end
			S_EMIT_HIGH: if (stat.out_free) begin
				op      = OP_EMIT_HIGH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== rtl/lcbg_datapath.sv =====
// arithmetic and output register of the class border generator
module lcbg_datapath #(
	parameter int MAX_CLASSES = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lcbg_pkg::op_t      op,
	output lcbg_pkg::status_t  stat,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	input  logic [5:0]         class_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] border,
	output logic [5:0]         border_index,
	output logic               last_border,
	output logic               bad_range
);
	import lcbg_pkg::*;

	localparam root_arr_t ROOTS = root_table();
	localparam logic [49:0] ONE = 50'd1 << FRAC_BITS;

	logic signed [31:0] lo_q, hi_q;
	logic [5:0]  n_q, i_q, cnt_q, p_q;
	logic [33:0] x_q;
	logic [30:0] m_q, acc_q;
	logic [61:0] prod_q;
	logic [23:0] frac_q;
	logic [LOGW-1:0] quot_q;
	logic [6:0]  rem_q;
	logic [31:0] step_q;
	logic [37:0] e_q;
	logic [49:0] pw_q;
	logic        out_valid_q;

	logic [5:0]  n_eff;
	logic signed [34:0] diff;
	logic [31:0] sq_t;
	logic [6:0]  rem_n;
	logic [15:0] int_part;
	logic [13:0] ip_raw;
	logic [4:0]  ip;
	logic [60:0] shifted;
	logic [4:0]  bit_idx;
	logic signed [49:0] bsum;
	logic signed [31:0] bclamp;

	always_comb begin
		if (class_count == '0)                      n_eff = 6'd1;
		else if (class_count > 6'(MAX_CLASSES))     n_eff = 6'(MAX_CLASSES);
		else                                        n_eff = class_count;
		diff     = 35'(high_bound) - 35'(low_bound) + 35'(ONE);
		sq_t     = prod_q[61:30];
		rem_n    = {rem_q[5:0], quot_q[LOGW-1]};
		int_part = 16'(p_q) - 16'(FRAC_BITS);
		ip_raw   = e_q[37:24];
		ip       = (ip_raw > 14'd30) ? 5'd30 : ip_raw[4:0];
		shifted  = ({30'd0, acc_q} << ip) >> (MANT_FRAC - FRAC_BITS);
		bit_idx  = 5'(LOG_FRAC - 1) - cnt_q[4:0];
		bsum     = 50'(lo_q) + signed'(pw_q) - signed'(ONE);
		if (bsum < 50'(lo_q))      bclamp = lo_q;
		else if (bsum > 50'(hi_q)) bclamp = hi_q;
		else                       bclamp = bsum[31:0];
	end

	assign stat.err       = (lo_q >= hi_q);
	assign stat.norm_done = x_q[33];
	assign stat.cnt_last  = (cnt_q == 6'(LOG_FRAC - 1));
	assign stat.div_last  = (cnt_q == 6'(LOGW - 1));
	assign stat.mid_done  = (i_q == n_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				lo_q <= low_bound;
				hi_q <= high_bound;
				n_q  <= n_eff;
				x_q  <= diff[33:0];
				p_q  <= 6'd33;
			end
			OP_NORM: begin
				x_q <= {x_q[32:0], 1'b0};
				p_q <= p_q - 6'd1;
			end
			OP_LOG_INIT: begin
				m_q    <= x_q[33:3];
				frac_q <= '0;
				cnt_q  <= '0;
			end
			OP_SQ_MUL: prod_q <= 62'(m_q) * 62'(m_q);
			OP_SQ_ADJ: begin
				if (sq_t[31]) begin
					frac_q <= {frac_q[22:0], 1'b1};
					m_q    <= sq_t[31:1];
				end else begin
					frac_q <= {frac_q[22:0], 1'b0};
					m_q    <= sq_t[30:0];
				end
				cnt_q <= cnt_q + 6'd1;
			end
			OP_DIV_INIT: begin
				quot_q <= {int_part, frac_q};
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			OP_DIV_STEP: begin
				if (rem_n >= {1'b0, n_q}) begin
					rem_q  <= rem_n - {1'b0, n_q};
					quot_q <= {quot_q[LOGW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					quot_q <= {quot_q[LOGW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			OP_DIV_DONE: begin
				step_q <= quot_q[31:0];
				i_q    <= 6'd1;
			end
			OP_EXP_INIT: begin
				e_q   <= 38'(i_q) * 38'(step_q);
				acc_q <= 31'd1 << MANT_FRAC;
				cnt_q <= '0;
			end
			OP_EXP_MUL: prod_q <= 62'(acc_q) * 62'(ROOTS[cnt_q[4:0]]);
			OP_EXP_ADJ: begin
				if (e_q[bit_idx]) acc_q <= prod_q[60:30];
				cnt_q <= cnt_q + 6'd1;
			end
			OP_EXP_SHIFT: pw_q <= shifted[49:0];
			OP_EMIT_ERR: begin
				border       <= '0;
				border_index <= '0;
				last_border  <= 1'b1;
				bad_range    <= 1'b1;
			end
			OP_EMIT_LOW: begin
				border       <= lo_q;
				border_index <= '0;
				last_border  <= 1'b0;
				bad_range    <= 1'b0;
			end
			OP_EMIT_MID: begin
				border       <= bclamp;
				border_index <= i_q;
				last_border  <= 1'b0;
				bad_range    <= 1'b0;
				i_q          <= i_q + 6'd1;
			end
			OP_EMIT_HIGH: begin
				border       <= hi_q;
				border_index <= n_q;
				last_border  <= 1'b1;
				bad_range    <= 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_EMIT_ERR || op == OP_EMIT_LOW ||
		             op == OP_EMIT_MID || op == OP_EMIT_HIGH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/log_class_border_generator_core.sv =====
// logarithmic class border generator: one request in, a run of class borders out
// Each request (low_bound, high_bound, class_count n) yields n+1 border items,
// low bound first and high bound last, borders in between at
// low + (high - low + 1)^(i/n) - 1 in signed Q16.16 and clamped to the range.
// A count of zero acts as one, a count above MAX_CLASSES is cut to MAX_CLASSES.
// Equal or reversed bounds give one item with bad_range and last_border set.
// Sequence: the request is taken in idle, a check state follows, then the border
// at low goes out; then a leading-one search, 24 squaring steps of a 31x31
// product for log2, each a multiply and an adjust state, and a bit-serial divide
// of the 40-bit log by n. Each inner border takes a check state, a 6x32 product,
// 24 multiply-and-adjust steps of a 31x31 product for exp2, a shift state and an
// emit state. Every emit waits while the output register is full; the next
// request is taken once the high bound has been handed to the output register,
// which holds one item.
module log_class_border_generator_core #(
	parameter int MAX_CLASSES = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	input  logic [5:0]         class_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] border,
	output logic [5:0]         border_index,
	output logic               last_border,
	output logic               bad_range
);
	import lcbg_pkg::*;

	`include "log_class_border_generator_core_defines.svh"

	// command from sequencer, status back from datapath
	op_t     op;
	status_t stat;

	lcbg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.op       (op)
	);

	lcbg_datapath #(
		.MAX_CLASSES (MAX_CLASSES),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.stat         (stat),
		.low_bound    (low_bound),
		.high_bound   (high_bound),
		.class_count  (class_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.border       (border),
		.border_index (border_index),
		.last_border  (last_border),
		.bad_range    (bad_range)
	);

	// an error item stands alone and carries a zero border
	`LCBG_ASSERT_NOW(a_err_item, out_valid && bad_range,
		last_border && border == 32'sd0 && border_index == 6'd0)
	// the block is busy right after taking a request
	`LCBG_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
	// a normal run always ends past index zero
	`LCBG_ASSERT_NOW(a_last_idx, out_valid && last_border && !bad_range,
		border_index != 6'd0)
	// a waiting item is not overwritten
	`LCBG_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(border))

endmodule
